[sv/tshp_pkg.sv]
// Shared types and constants of the transport stream header parser.
package tshp_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'h47;
	localparam logic [7:0] PCR_BYTES = 8'd6;

	localparam logic [3:0] POS_SYNC     = 4'd0;
	localparam logic [3:0] POS_HDR_FIRST = 4'd1;
	localparam logic [3:0] POS_HDR_LAST = 4'd3;
	localparam logic [3:0] POS_ALEN     = 4'd4;
	localparam logic [3:0] POS_AFLAGS   = 4'd5;
	localparam logic [3:0] POS_PCR_LAST = 4'd11;

	localparam int ADAPT_BIT = 5;
	localparam int PCR_FLAG_BIT = 4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_SYNC  = 2'd1;
	localparam logic [1:0] ST_SHORT_PCR = 2'd2;

	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_START  = 3'd1;
	localparam logic [2:0] OP_HDR    = 3'd2;
	localparam logic [2:0] OP_ALEN   = 3'd3;
	localparam logic [2:0] OP_AFLAGS = 3'd4;
	localparam logic [2:0] OP_PCR    = 3'd5;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic       emit;
		logic [1:0] status;
	} op_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  header_flags;
		logic [12:0] pid;
		logic [1:0]  scrambling;
		logic        adaptation_present;
		logic        payload_present;
		logic [3:0]  continuity;
		logic [7:0]  adaptation_length;
		logic [7:0]  adaptation_flags;
		logic [32:0] pcr_base;
		logic [8:0]  pcr_extension;
	} res_t;

endpackage

[sv/tshp_fifo.sv]
// Small register queue used between the parser stages and at the result side.
module tshp_fifo #(
	parameter type item_t = logic,
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  item_t wr_item,
	output logic  full,
	input  logic  rd_en,
	output item_t rd_item,
	output logic  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/tshp_front.sv]
// Front stage: tracks packet position and classifies each byte into a field operation.
module tshp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [7:0]    data_byte,
	input  logic          packet_first,
	input  logic          q_full,
	output logic          q_wr,
	output tshp_pkg::op_t q_item
);

	logic [3:0] pos_q;
	logic       done_q;
	logic [7:0] aleft_q;
	logic [3:0] pos_n;
	logic       done_n;
	logic [7:0] aleft_n;
	logic [3:0] p;
	logic       d;
	logic [7:0] a;
	logic [7:0] a_dec;
	logic       accept;

	assign accept = push && !q_full;
	assign p = packet_first ? tshp_pkg::POS_SYNC : pos_q;
	assign d = packet_first ? 1'b0 : done_q;
	assign a = packet_first ? 8'd0 : aleft_q;
	assign a_dec = a - 8'd1;

	always_comb begin
		q_item = '0;
		q_item.kind = tshp_pkg::OP_NONE;
		q_item.status = tshp_pkg::ST_OK;
		q_item.data = data_byte;
		q_wr = 1'b0;
		pos_n = pos_q;
		done_n = done_q;
		aleft_n = aleft_q;
		if (accept) begin
			pos_n = p;
			done_n = d;
			aleft_n = a;
			if (!d) begin
				q_wr = 1'b1;
				pos_n = p + 4'd1;
				case (p) inside
					tshp_pkg::POS_SYNC: begin
						if (data_byte != tshp_pkg::SYNC_BYTE) begin
							q_item.kind = tshp_pkg::OP_NONE;
							q_item.emit = 1'b1;
							q_item.status = tshp_pkg::ST_BAD_SYNC;
							done_n = 1'b1;
						end else begin
							q_item.kind = tshp_pkg::OP_START;
						end
					end
					[tshp_pkg::POS_HDR_FIRST:tshp_pkg::POS_HDR_LAST]: begin
						q_item.kind = tshp_pkg::OP_HDR;
						if (p == tshp_pkg::POS_HDR_LAST && !data_byte[tshp_pkg::ADAPT_BIT]) begin
							q_item.emit = 1'b1;
							done_n = 1'b1;
						end
					end
					tshp_pkg::POS_ALEN: begin
						q_item.kind = tshp_pkg::OP_ALEN;
						aleft_n = data_byte;
						if (data_byte == 8'd0) begin
							q_item.emit = 1'b1;
							done_n = 1'b1;
						end
					end
					tshp_pkg::POS_AFLAGS: begin
						q_item.kind = tshp_pkg::OP_AFLAGS;
						aleft_n = a_dec;
						if (a_dec == 8'd0 || !data_byte[tshp_pkg::PCR_FLAG_BIT]) begin
							q_item.emit = 1'b1;
							done_n = 1'b1;
						end else if (a_dec < tshp_pkg::PCR_BYTES) begin
							q_item.emit = 1'b1;
							q_item.status = tshp_pkg::ST_SHORT_PCR;
							done_n = 1'b1;
						end
					end
					default: begin
						q_item.kind = tshp_pkg::OP_PCR;
						if (p >= tshp_pkg::POS_PCR_LAST) begin
							aleft_n = a - tshp_pkg::PCR_BYTES;
							q_item.emit = 1'b1;
							done_n = 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			done_q <= 1'b1;
			aleft_q <= '0;
		end else begin
			pos_q <= pos_n;
			done_q <= done_n;
			aleft_q <= aleft_n;
		end
	end

endmodule

[sv/tshp_back.sv]
// Back stage: applies field operations to the header registers and builds results.
module tshp_back (
	input  logic           clk,
	input  logic           q_empty,
	input  tshp_pkg::op_t  q_item,
	output logic           q_rd,
	input  logic           r_full,
	output logic           r_wr,
	output tshp_pkg::res_t r_item
);

	logic [23:0] hdr_q;
	logic [7:0]  alen_q;
	logic [7:0]  aflags_q;
	logic [47:0] pcr_q;
	logic [23:0] hdr_n;
	logic [7:0]  alen_n;
	logic [7:0]  aflags_n;
	logic [47:0] pcr_n;
	logic        go;

	assign go = !q_empty && (!q_item.emit || !r_full);
	assign q_rd = go;
	assign r_wr = go && q_item.emit;

	always_comb begin
		hdr_n = hdr_q;
		alen_n = alen_q;
		aflags_n = aflags_q;
		pcr_n = pcr_q;
		case (q_item.kind)
			tshp_pkg::OP_START: begin
				hdr_n = '0;
				alen_n = '0;
				aflags_n = '0;
				pcr_n = '0;
			end
			tshp_pkg::OP_HDR:    hdr_n = {hdr_q[15:0], q_item.data};
			tshp_pkg::OP_ALEN:   alen_n = q_item.data;
			tshp_pkg::OP_AFLAGS: aflags_n = q_item.data;
			tshp_pkg::OP_PCR:    pcr_n = {pcr_q[39:0], q_item.data};
			default: ;
		endcase
	end

	always_comb begin
		r_item = '0;
		r_item.status = q_item.status;
		if (q_item.status != tshp_pkg::ST_BAD_SYNC) begin
			r_item.header_flags = hdr_n[23:21];
			r_item.pid = hdr_n[20:8];
			r_item.scrambling = hdr_n[7:6];
			r_item.adaptation_present = hdr_n[5];
			r_item.payload_present = hdr_n[4];
			r_item.continuity = hdr_n[3:0];
			r_item.adaptation_length = alen_n;
			r_item.adaptation_flags = aflags_n;
			if (q_item.kind == tshp_pkg::OP_PCR) begin
				r_item.pcr_base = pcr_n[47:15];
				r_item.pcr_extension = pcr_n[8:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			hdr_q <= hdr_n;
			alen_q <= alen_n;
			aflags_q <= aflags_n;
			pcr_q <= pcr_n;
		end
	end

endmodule

[sv/transport_stream_header_parser.sv]
// Top level of the transport stream header parser.
// Takes one stream byte per cycle and gives one result per packet not cut short by the next
// packet_first, once its sync byte is bad or its header, adaptation length and flags and, when
// flagged, its PCR have been read. A byte is taken every cycle while full is low; full rises
// only when the operation queue between the classifying front stage and the field-building
// back stage fills, which happens when results are not popped and the result queue is full.
// The closing byte's operation and then its result are registered in the two queues in turn.
module transport_stream_header_parser #(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        packet_first,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [2:0]  header_flags,
	output logic [12:0] pid,
	output logic [1:0]  scrambling,
	output logic        adaptation_present,
	output logic        payload_present,
	output logic [3:0]  continuity,
	output logic [7:0]  adaptation_length,
	output logic [7:0]  adaptation_flags,
	output logic [32:0] pcr_base,
	output logic [8:0]  pcr_extension
);

	tshp_pkg::op_t  op_wr_item;
	tshp_pkg::op_t  op_rd_item;
	tshp_pkg::res_t res_wr_item;
	tshp_pkg::res_t res_rd_item;
	logic op_wr;
	logic op_rd;
	logic op_full;
	logic op_empty;
	logic res_wr;
	logic res_full;

	assign full = op_full;

	tshp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.data_byte    (data_byte),
		.packet_first (packet_first),
		.q_full       (op_full),
		.q_wr         (op_wr),
		.q_item       (op_wr_item)
	);

	tshp_fifo #(
		.item_t (tshp_pkg::op_t),
		.DEPTH  (MID_DEPTH)
	) u_op_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (op_wr),
		.wr_item (op_wr_item),
		.full    (op_full),
		.rd_en   (op_rd),
		.rd_item (op_rd_item),
		.empty   (op_empty)
	);

	tshp_back u_back (
		.clk     (clk),
		.q_empty (op_empty),
		.q_item  (op_rd_item),
		.q_rd    (op_rd),
		.r_full  (res_full),
		.r_wr    (res_wr),
		.r_item  (res_wr_item)
	);

	tshp_fifo #(
		.item_t (tshp_pkg::res_t),
		.DEPTH  (OUT_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_wr),
		.wr_item (res_wr_item),
		.full    (res_full),
		.rd_en   (pop),
		.rd_item (res_rd_item),
		.empty   (empty)
	);

	assign status = res_rd_item.status;
	assign header_flags = res_rd_item.header_flags;
	assign pid = res_rd_item.pid;
	assign scrambling = res_rd_item.scrambling;
	assign adaptation_present = res_rd_item.adaptation_present;
	assign payload_present = res_rd_item.payload_present;
	assign continuity = res_rd_item.continuity;
	assign adaptation_length = res_rd_item.adaptation_length;
	assign adaptation_flags = res_rd_item.adaptation_flags;
	assign pcr_base = res_rd_item.pcr_base;
	assign pcr_extension = res_rd_item.pcr_extension;

	a_status_known: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status == tshp_pkg::ST_OK || status == tshp_pkg::ST_BAD_SYNC ||
			status == tshp_pkg::ST_SHORT_PCR))
		else $error("result status out of range");

	a_bad_sync_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == tshp_pkg::ST_BAD_SYNC) |->
			(pid == '0 && header_flags == '0 && adaptation_length == '0 &&
			adaptation_flags == '0))
		else $error("bad sync result carries header fields");

	a_no_pcr_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != tshp_pkg::ST_OK) |-> (pcr_base == '0 && pcr_extension == '0))
		else $error("PCR reported on a failed packet");

	a_short_needs_adapt: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == tshp_pkg::ST_SHORT_PCR) |->
			(adaptation_present && adaptation_flags[tshp_pkg::PCR_FLAG_BIT]))
		else $error("short PCR status without flagged adaptation field");

endmodule

[verif/ts_header_checker.sv]
`timescale 1ns / 1ps
// Checker for the transport stream header parser: predicts each packet result and compares it.
module ts_header_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  data_byte,
	input  logic        packet_first,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  status,
	input  logic [2:0]  header_flags,
	input  logic [12:0] pid,
	input  logic [1:0]  scrambling,
	input  logic        adaptation_present,
	input  logic        payload_present,
	input  logic [3:0]  continuity,
	input  logic [7:0]  adaptation_length,
	input  logic [7:0]  adaptation_flags,
	input  logic [32:0] pcr_base,
	input  logic [8:0]  pcr_extension,
	output int          errors,
	output int          outstanding,
	output int          checked
);

	logic [3:0]     position;
	logic           waiting_sync;
	logic [31:0]    hdr_store;
	logic [7:0]     adapt_remaining;
	logic [47:0]    pcr_shift;
	logic [7:0]     adapt_len;
	tshp_pkg::res_t packet_results[$];

	initial begin
		errors = 0;
		outstanding = 0;
		checked = 0;
	end

	task automatic clear_packet();
		position = '0;
		hdr_store = '0;
		adapt_remaining = '0;
		pcr_shift = '0;
		adapt_len = '0;
	endtask

	task automatic close_packet(input logic [1:0] code, input logic with_pcr);
		tshp_pkg::res_t r;
		r = '0;
		r.status = code;
		if (code != tshp_pkg::ST_BAD_SYNC) begin
			r.header_flags = hdr_store[23:21];
			r.pid = hdr_store[20:8];
			r.scrambling = hdr_store[7:6];
			r.adaptation_present = hdr_store[5];
			r.payload_present = hdr_store[4];
			r.continuity = hdr_store[3:0];
			r.adaptation_length = adapt_len;
			r.adaptation_flags = hdr_store[31:24];
			if (with_pcr) begin
				r.pcr_base = pcr_shift[47:15];
				r.pcr_extension = pcr_shift[8:0];
			end
		end
		waiting_sync = 1'b1;
		packet_results.push_back(r);
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic first);
		logic [3:0] pos;
		if (first) begin
			clear_packet();
			waiting_sync = 1'b0;
		end
		if (waiting_sync)
			return;
		pos = position;
		position = pos + 4'd1;
		if (pos == tshp_pkg::POS_SYNC) begin
			if (b != tshp_pkg::SYNC_BYTE)
				close_packet(tshp_pkg::ST_BAD_SYNC, 1'b0);
		end else if (pos <= tshp_pkg::POS_HDR_LAST) begin
			hdr_store = {8'h00, hdr_store[15:0], b};
			if (pos == tshp_pkg::POS_HDR_LAST && !b[tshp_pkg::ADAPT_BIT])
				close_packet(tshp_pkg::ST_OK, 1'b0);
		end else if (pos == tshp_pkg::POS_ALEN) begin
			adapt_len = b;
			adapt_remaining = b;
			if (b == 8'd0)
				close_packet(tshp_pkg::ST_OK, 1'b0);
		end else if (pos == tshp_pkg::POS_AFLAGS) begin
			hdr_store[31:24] = b;
			adapt_remaining = adapt_remaining - 8'd1;
			if (adapt_remaining == 8'd0 || !b[tshp_pkg::PCR_FLAG_BIT])
				close_packet(tshp_pkg::ST_OK, 1'b0);
			else if (adapt_remaining < tshp_pkg::PCR_BYTES)
				close_packet(tshp_pkg::ST_SHORT_PCR, 1'b0);
		end else begin
			pcr_shift = {pcr_shift[39:0], b};
			if (pos >= tshp_pkg::POS_PCR_LAST) begin
				adapt_remaining = adapt_remaining - tshp_pkg::PCR_BYTES;
				close_packet(tshp_pkg::ST_OK, 1'b1);
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	task automatic check_result();
		tshp_pkg::res_t want;
		if (packet_results.size() == 0) begin
			$error("result transaction with none pending: status %0d pid %0h", status, pid);
			errors++;
			return;
		end
		want = packet_results.pop_front();
		checked++;
		compare_field("status", 64'(want.status), 64'(status));
		compare_field("header_flags", 64'(want.header_flags), 64'(header_flags));
		compare_field("pid", 64'(want.pid), 64'(pid));
		compare_field("scrambling", 64'(want.scrambling), 64'(scrambling));
		compare_field("adaptation_present", 64'(want.adaptation_present),
			64'(adaptation_present));
		compare_field("payload_present", 64'(want.payload_present), 64'(payload_present));
		compare_field("continuity", 64'(want.continuity), 64'(continuity));
		compare_field("adaptation_length", 64'(want.adaptation_length),
			64'(adaptation_length));
		compare_field("adaptation_flags", 64'(want.adaptation_flags), 64'(adaptation_flags));
		compare_field("pcr_base", 64'(want.pcr_base), 64'(pcr_base));
		compare_field("pcr_extension", 64'(want.pcr_extension), 64'(pcr_extension));
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_packet();
			waiting_sync = 1'b1;
			packet_results.delete();
		end else begin
			if (pop && !empty)
				check_result();
			if (push && !full)
				parse_byte(data_byte, packet_first);
		end
		outstanding = packet_results.size();
	end

endmodule

[verif/tb_transport_stream_header_parser.sv]
`timescale 1ns / 1ps
// Testbench top for the transport stream header parser: stimulus, receiver stalls and verdict.
module tb_transport_stream_header_parser;

	localparam int RANDOM_ITEMS = 700;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic [7:0] value;
		logic       first;
	} stream_byte_t;

	typedef enum logic [1:0] {POP_ALWAYS, POP_COIN, POP_RARE, POP_HOLD} pop_mode_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        packet_first;
	logic        empty;
	logic        pop;
	logic [1:0]  status;
	logic [2:0]  header_flags;
	logic [12:0] pid;
	logic [1:0]  scrambling;
	logic        adaptation_present;
	logic        payload_present;
	logic [3:0]  continuity;
	logic [7:0]  adaptation_length;
	logic [7:0]  adaptation_flags;
	logic [32:0] pcr_base;
	logic [8:0]  pcr_extension;
	int          errors;
	int          outstanding;
	int          checked;

	stream_byte_t byte_stream[$];
	int           items;
	int           whole_packets;
	int           bad_sync_packets;
	int           cut_packets;
	int           idx;
	int           burst;
	int           gap;
	pop_mode_t    pop_mode;
	int           span;

	transport_stream_header_parser DUT (.*);

	ts_header_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("** transport_stream_header_parser: FAILED **");
		$finish;
	end

	initial begin
		pop = 1'b0;
		forever begin
			pop_mode = pop_mode_t'($urandom_range(0, 3));
			span = $urandom_range(5, 60);
			repeat (span) begin
				@(negedge clk);
				case (pop_mode)
					POP_ALWAYS: pop = 1'b1;
					POP_COIN: pop = 1'($urandom_range(0, 1));
					POP_RARE: pop = ($urandom_range(0, 7) == 0);
					default: pop = 1'b0;
				endcase
			end
		end
	end

	task automatic add_byte(input logic [7:0] v, input logic first);
		stream_byte_t s;
		s.value = v;
		s.first = first;
		byte_stream.push_back(s);
	endtask

	// payload bytes after a finished header or a bad sync byte, ignored by the block
	task automatic add_trailer();
		int n;
		n = $urandom_range(0, 3);
		repeat (n)
			add_byte(8'($urandom_range(0, 255)), 1'b0);
		items += n;
	endtask

	task automatic add_random_packet();
		logic [7:0] body[$];
		logic [7:0] hb;
		logic [7:0] alen;
		logic [7:0] aflags;
		int kind;
		int keep;
		kind = $urandom_range(0, 99);
		if (kind < 6) begin
			keep = $urandom_range(1, 6);
			repeat (keep)
				add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			items += keep;
			return;
		end
		if (kind < 14) begin
			hb = 8'($urandom_range(0, 255));
			if (hb == tshp_pkg::SYNC_BYTE)
				hb = ~tshp_pkg::SYNC_BYTE;
			add_byte(hb, 1'b1);
			bad_sync_packets++;
			items++;
			add_trailer();
			return;
		end
		body.push_back(tshp_pkg::SYNC_BYTE);
		body.push_back(8'($urandom_range(0, 255)));
		body.push_back(8'($urandom_range(0, 255)));
		hb = 8'($urandom_range(0, 255));
		hb[tshp_pkg::ADAPT_BIT] = ($urandom_range(0, 9) < 7);
		body.push_back(hb);
		if (hb[tshp_pkg::ADAPT_BIT]) begin
			case ($urandom_range(0, 9))
				0: alen = 8'd0;
				1, 2, 3: alen = 8'($urandom_range(1, 7));
				9: alen = 8'($urandom_range(184, 255));
				default: alen = 8'($urandom_range(8, 183));
			endcase
			body.push_back(alen);
			if (alen != 8'd0) begin
				aflags = 8'($urandom_range(0, 255));
				aflags[tshp_pkg::PCR_FLAG_BIT] = ($urandom_range(0, 3) != 0);
				body.push_back(aflags);
				if (aflags[tshp_pkg::PCR_FLAG_BIT] && alen > tshp_pkg::PCR_BYTES)
					repeat (tshp_pkg::PCR_BYTES)
						body.push_back(8'($urandom_range(0, 255)));
			end
		end
		if (kind < 24) begin
			keep = $urandom_range(1, body.size() - 1);
			cut_packets++;
		end else begin
			keep = body.size();
			whole_packets++;
		end
		for (int i = 0; i < keep; i++)
			add_byte(body[i], i == 0);
		items += keep;
		if (keep == body.size())
			add_trailer();
	endtask

	task automatic add_directed();
		// stray byte before any packet
		add_byte(8'h47, 1'b0);
		// bad sync
		add_byte(8'hFF, 1'b1);
		// header cut short by the next packet
		add_byte(8'h47, 1'b1);
		add_byte(8'h1F, 1'b0);
		// all header bits set, zero adaptation length, then an ignored byte
		add_byte(8'h47, 1'b1);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h47, 1'b0);
		// longest adaptation field, all flags and a full-scale PCR
		add_byte(8'h47, 1'b1);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h20, 1'b0);
		add_byte(8'hB7, 1'b0);
		repeat (7)
			add_byte(8'hFF, 1'b0);
		// PCR flagged but only five bytes left
		add_byte(8'h47, 1'b1);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h20, 1'b0);
		add_byte(8'h06, 1'b0);
		add_byte(8'h10, 1'b0);
		items += byte_stream.size();
		whole_packets += 3;
		bad_sync_packets++;
		cut_packets++;
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		data_byte = '0;
		packet_first = 1'b0;
		items = 0;
		whole_packets = 0;
		bad_sync_packets = 0;
		cut_packets = 0;
		add_directed();
		while (items < RANDOM_ITEMS)
			add_random_packet();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		idx = 0;
		while (idx < byte_stream.size()) begin
			burst = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
			while (burst > 0 && idx < byte_stream.size()) begin
				@(negedge clk);
				push = 1'b1;
				data_byte = byte_stream[idx].value;
				packet_first = byte_stream[idx].first;
				do
					@(posedge clk);
				while (full);
				idx++;
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				push = 1'b0;
				data_byte = 8'($urandom_range(0, 255));
				packet_first = 1'($urandom_range(0, 1));
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		push = 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Streamed %0d bytes: %0d complete headers, %0d bad sync, %0d cut short.",
			byte_stream.size(), whole_packets, bad_sync_packets, cut_packets);
		$display("Result transactions checked: %0d, mismatches: %0d.", checked, errors);
		if (errors == 0 && outstanding == 0 && empty)
			$display("** transport_stream_header_parser: PASSED **");
		else
			$display("** transport_stream_header_parser: FAILED **");
		$finish;
	end

endmodule

[files.f]
sv/tshp_pkg.sv
sv/tshp_fifo.sv
sv/tshp_front.sv
sv/tshp_back.sv
sv/transport_stream_header_parser.sv
verif/ts_header_checker.sv
verif/tb_transport_stream_header_parser.sv
